@@ design/elevator_pd_position_step_core_assert.svh @@
// Assertion macros shared by the elevator PD position step RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ELEVATOR_PD_POSITION_STEP_CORE_ASSERT_SVH
`define ELEVATOR_PD_POSITION_STEP_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EPPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EPPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/epps_pkg.sv @@
// Package for the elevator PD position step: widths, codes, payload structs.
// No dependencies; used by the core, epps_cfg and epps_law.
`timescale 1ns / 1ps
`default_nettype none

package epps_pkg;

  localparam int CountW   = 16;
  localparam int ErrW     = CountW + 1;
  localparam int CmdW     = 16;
  localparam int TolW     = 10;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 2;
  localparam int StatusW  = 2;

  // Gains and normalization of the PD law.
  localparam logic signed [3:0] Kp = 4'sd6;
  localparam logic signed [3:0] Kd = 4'sd3;
  localparam longint unsigned Norm = 893;
  localparam int Q15Shift = 15;

  // Width of 6*e + 3*(e - prev); worst case magnitude is 12 * 65535.
  localparam int SumW = 21;

  // Magnitudes at or above 2^MagLoW overflow any 16-bit clamp after scaling.
  localparam int MagLoW = 11;

  // floor(x / 893) for x < 2^26 equals (x * RecipC) >> 36 with RecipC rounded up.
  localparam int RecipExp = 36;
  localparam longint unsigned RecipVal = ((64'd1 << RecipExp) + Norm - 1) / Norm;
  localparam int RecipW = 27;
  localparam logic [RecipW-1:0] RecipC = RecipW'(RecipVal);
  localparam int ProdW = MagLoW + RecipW;
  localparam int QuotW = 17;
  localparam int ProdShift = RecipExp - Q15Shift;

  localparam logic signed [CmdW-1:0] MaxOutRst = 16'sd32767;
  localparam logic signed [CmdW-1:0] MinOutRst = -16'sd32768;
  localparam logic [TolW-1:0] TolRst = 10'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_OUT   = 2'd0,
    CFG_MIN_OUT   = 2'd1,
    CFG_TOLERANCE = 2'd2
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    ST_DRIVING     = 2'd0,
    ST_AT_TARGET   = 2'd1,
    ST_TOP_STOP    = 2'd2,
    ST_BOTTOM_STOP = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [CmdW-1:0] max_out;
    logic signed [CmdW-1:0] min_out;
    logic [TolW-1:0]        tolerance;
  } cfg_t;

  typedef struct packed {
    logic signed [CountW-1:0] encoder_count;
    logic signed [CountW-1:0] target_count;
    logic                     target_is_bottom;
    logic                     top_hit;
    logic                     bottom_hit;
  } in_item_t;

  typedef struct packed {
    logic signed [CmdW-1:0] motor_command;
    status_e                status;
    logic                   still_active;
  } res_t;

endpackage

`default_nettype wire

@@ design/epps_in_if.sv @@
// Input channel of the elevator PD position step: valid/ready and one tick's fields.
// Depends on no package.
`timescale 1ns / 1ps
`default_nettype none

interface epps_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] encoder_count;
  logic signed [15:0] target_count;
  logic               target_is_bottom;
  logic               top_left_switch;
  logic               top_right_switch;
  logic               bottom_left_switch;
  logic               bottom_right_switch;

  modport source (
    output valid, encoder_count, target_count, target_is_bottom,
    output top_left_switch, top_right_switch, bottom_left_switch, bottom_right_switch,
    input  ready
  );

  modport sink (
    input  valid, encoder_count, target_count, target_is_bottom,
    input  top_left_switch, top_right_switch, bottom_left_switch, bottom_right_switch,
    output ready
  );
endinterface

`default_nettype wire

@@ design/epps_out_if.sv @@
// Output channel of the elevator PD position step: valid/ready and the result fields.
// Depends on no package.
`timescale 1ns / 1ps
`default_nettype none

interface epps_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] motor_command;
  logic [1:0]         status;
  logic               still_active;

  modport source (
    output valid, motor_command, status, still_active,
    input  ready
  );

  modport sink (
    input  valid, motor_command, status, still_active,
    output ready
  );
endinterface

`default_nettype wire

@@ design/elevator_pd_position_step_core.sv @@
// Elevator PD position step: one motor command per control tick.
// An accepted input transaction is held in the input register, and its result then in the result register.
// Throughput: one transaction per cycle while results are read; the whole PD law fits between the input
// register and the result register, and the stored error closes in that one stage.
// Reset (rst_ni low, asynchronous): pipeline empty, stored error zero, clamps and
// tolerance at their reset values. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "elevator_pd_position_step_core_assert.svh"

module elevator_pd_position_step_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  epps_in_if.sink                        in_i,
  epps_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [epps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [epps_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import epps_pkg::*;

  // Configuration registers. The user must write them only while the block is idle;
  // the block does not enforce this, and the datapath reads them without any shadowing.
  cfg_t cfg;

  epps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Handshake. The result register frees up when it is empty or being read;
  // the input stage then moves forward, and a new transaction may enter the
  // input register in the same cycle. A waiting result therefore never blocks
  // acceptance while the input register is empty.
  logic     s0_valid_q, s0_valid_d;
  in_item_t s0_item_q;
  logic     out_valid_q, out_valid_d;
  res_t     out_res_q;
  logic     out_free;
  logic     in_fire;
  logic     s0_fire;
  logic     out_fire;

  assign out_free = !out_valid_q || out_o.ready;
  assign s0_fire  = s0_valid_q && out_free;
  assign in_i.ready = !s0_valid_q || out_free;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (in_fire) begin
      s0_valid_d = 1'b1;
    end else if (s0_fire) begin
      s0_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s0_fire) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  // Input register. The four limit switches are reduced to a top and a
  // bottom hit before they are stored.
  in_item_t in_item;

  always_comb begin
    in_item.encoder_count    = in_i.encoder_count;
    in_item.target_count     = in_i.target_count;
    in_item.target_is_bottom = in_i.target_is_bottom;
    in_item.top_hit          = in_i.top_left_switch || in_i.top_right_switch;
    in_item.bottom_hit       = in_i.bottom_left_switch || in_i.bottom_right_switch;
  end

  // The PD law itself, including the next value of the stored error.
  logic signed [ErrW-1:0] prev_err_q, prev_err_d;
  res_t                   law_res;

  epps_law u_law (
    .item_i     (s0_item_q),
    .cfg_i      (cfg),
    .prev_err_i (prev_err_q),
    .res_o      (law_res),
    .prev_err_o (prev_err_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_err_q  <= '0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
      if (s0_fire) begin
        prev_err_q <= prev_err_d;
      end
    end
  end

  // Payload registers carry no reset; their valid flags qualify them.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_item_q <= in_item;
    end
    if (s0_fire) begin
      out_res_q <= law_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.motor_command = out_res_q.motor_command;
  assign out_o.status        = out_res_q.status;
  assign out_o.still_active  = out_res_q.still_active;

  // A stage that moves forward always lands in the result register.
  `EPPS_ASSERT_NEXT(a_s0_to_out, s0_fire, out_valid_q, "result lost after input stage")
  // A stalled input stage keeps its transaction unchanged.
  `EPPS_ASSERT_NEXT(a_s0_hold, s0_valid_q && !out_free,
                    s0_valid_q && $stable(s0_item_q), "stalled input stage changed")
  // The stored error changes only when a transaction is processed.
  `EPPS_ASSERT_NEXT(a_prev_hold, !s0_fire, $stable(prev_err_q),
                    "stored error changed without a transaction")
  // Any outcome other than driving both zeroes the command and clears the error.
  `EPPS_ASSERT_NEXT(a_stop_clears, s0_fire && (law_res.status != ST_DRIVING),
                    prev_err_q == '0, "stored error not cleared on stop")
  `EPPS_ASSERT_NOW(a_stop_zero_cmd, out_valid_q && (out_res_q.status != ST_DRIVING),
                   out_res_q.motor_command == '0, "nonzero command with stop status")

endmodule

`default_nettype wire

@@ design/epps_cfg.sv @@
// Configuration registers of the elevator PD position step (clamps, tolerance).
// Depends on epps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module epps_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [epps_pkg::CfgIdxW-1:0]   idx_i,
  input  logic [epps_pkg::CfgDataW-1:0]  wdata_i,
  output epps_pkg::cfg_t                 cfg_o
);
  import epps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_MAX_OUT:   cfg_d.max_out   = $signed(wdata_i[CmdW-1:0]);
        CFG_MIN_OUT:   cfg_d.min_out   = $signed(wdata_i[CmdW-1:0]);
        CFG_TOLERANCE: cfg_d.tolerance = wdata_i[TolW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_out   <= MaxOutRst;
      cfg_q.min_out   <= MinOutRst;
      cfg_q.tolerance <= TolRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ design/epps_law.sv @@
// PD law of one control tick: error, scaled command, clamps and limit stops.
// Depends on epps_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module epps_law (
  input  epps_pkg::in_item_t                 item_i,
  input  epps_pkg::cfg_t                     cfg_i,
  input  logic signed [epps_pkg::ErrW-1:0]   prev_err_i,
  output epps_pkg::res_t                     res_o,
  output logic signed [epps_pkg::ErrW-1:0]   prev_err_o
);
  import epps_pkg::*;

  logic signed [ErrW-1:0]   err;
  logic [ErrW-1:0]          err_mag;
  logic                     at_target;
  logic signed [SumW-1:0]   err_x;
  logic signed [SumW-1:0]   diff_x;
  logic signed [SumW-1:0]   pd_sum;
  logic [SumW-1:0]          sum_mag;
  logic                     sum_big;
  logic [ProdW-1:0]         prod;
  logic [QuotW-1:0]         quot;
  logic signed [QuotW:0]    raw;
  logic signed [CmdW-1:0]   cmd;

  assign err     = ErrW'(item_i.target_count) - ErrW'(item_i.encoder_count);
  assign err_mag = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);
  assign at_target = err_mag <= ErrW'(cfg_i.tolerance);

  assign err_x  = SumW'(err);
  assign diff_x = SumW'(err) - SumW'(prev_err_i);
  assign pd_sum = err_x * Kp + diff_x * Kd;

  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign sum_mag = pd_sum[SumW-1] ? SumW'(-pd_sum) : SumW'(pd_sum);
  assign sum_big = |sum_mag[SumW-1:MagLoW];
  assign prod    = ProdW'(sum_mag[MagLoW-1:0]) * ProdW'(RecipC);
  assign quot    = sum_big ? '1 : prod[ProdShift +: QuotW];
  assign raw     = pd_sum[SumW-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  // Upper clamp is tested first, so crossed clamps give max_out above it, else min_out.
  always_comb begin
    if (raw > (QuotW+1)'(cfg_i.max_out)) begin
      cmd = cfg_i.max_out;
    end else if (raw < (QuotW+1)'(cfg_i.min_out)) begin
      cmd = cfg_i.min_out;
    end else begin
      cmd = CmdW'(raw);
    end
  end

  always_comb begin
    res_o.motor_command = '0;
    prev_err_o          = '0;
    if (at_target) begin
      res_o.status = ST_AT_TARGET;
    end else if ((cmd > 0) && item_i.top_hit) begin
      res_o.status = ST_TOP_STOP;
    end else if (item_i.target_is_bottom && item_i.bottom_hit) begin
      res_o.status = ST_BOTTOM_STOP;
    end else begin
      res_o.status        = ST_DRIVING;
      res_o.motor_command = cmd;
      prev_err_o          = err;
    end
    res_o.still_active = (res_o.status == ST_DRIVING) || (res_o.status == ST_AT_TARGET);
  end

endmodule

`default_nettype wire
